FILE: sv/ces_pkg.sv
// Shared types, widths and key helper for the coordinate-entry sorter.
package ces_pkg;

    localparam int COORD_W = 31;
    localparam int VALUE_W = 64;
    localparam int POS_W   = 6;
    localparam int KEY_W   = 2 * COORD_W + POS_W;
    localparam int S_DATA_W = 128;
    localparam int M_DATA_W = 136;

    typedef logic [KEY_W-1:0] sort_key_t;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [COORD_W-1:0] col;
        logic [COORD_W-1:0] row;
    } entry_t;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_SCAN,
        ST_OUT
    } sort_state_t;

    // Major coordinate, minor coordinate, then load position.
    function automatic sort_key_t make_key(input logic col_major, input entry_t e,
                                           input logic [POS_W-1:0] pos);
        sort_key_t k;
        if (col_major) begin
            k = {e.col, e.row, pos};
        end else begin
            k = {e.row, e.col, pos};
        end
        return k;
    endfunction

endpackage

FILE: sv/coo_entry_sort.sv
// Coordinate-form entry sorter: loads a set of entries, then emits them in key order.
// Loading takes one cycle per entry beat into a single-port entry memory (one write, one
// registered read per cycle). After the beat marked tlast, each result is found by a
// selection scan that reads each of the n stored entries in turn and keeps the smallest
// key above the previous result; the result beat follows the scan. The order is
// row, column, load position (or column, row, position when column_major is set, sampled
// when the tlast beat is taken). Entries beyond MAX_ENTRIES are dropped and every result
// of that set carries the overflow flag. No clearing pass is needed after reset.
module coo_entry_sort #(
    parameter int MAX_ENTRIES = 64
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_data,      // column_major
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [ces_pkg::S_DATA_W-1:0] s_tdata,      // row_index, col_index, entry_value
    input  logic                        s_tlast,       // last_entry
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [ces_pkg::M_DATA_W-1:0] m_tdata,      // out_row, out_col, out_value,
                                                       // source_position
    output logic                        m_tlast,       // final_result
    output logic                        m_tuser        // overflowed
);
    import ces_pkg::*;

    localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
    localparam logic [CNT_W-1:0] MaxCnt = CNT_W'(MAX_ENTRIES);

    entry_t mem [MAX_ENTRIES];

    sort_state_t state_reg, state_next;
    logic             col_major_reg;
    logic             sort_major_reg;
    logic [CNT_W-1:0] count_reg;
    logic             ovf_reg;
    logic [CNT_W-1:0] issue_reg;
    logic [CNT_W-1:0] emit_reg;
    logic             rd_vld_reg;
    logic             rd_last_reg;
    logic [IDX_W-1:0] rd_idx_reg;
    entry_t           rd_data_reg;
    logic             have_prev_reg;
    sort_key_t        prev_key_reg;
    logic             have_best_reg;
    sort_key_t        best_key_reg;
    entry_t           best_reg;
    logic [IDX_W-1:0] best_idx_reg;

    entry_t           in_entry;
    logic             in_acc, out_acc, do_issue, take, is_final;
    logic [POS_W-1:0] rd_pos, best_pos;
    sort_key_t        rd_key;

    assign in_entry = entry_t'(s_tdata[2*COORD_W+VALUE_W-1:0]);
    assign in_acc   = s_tvalid && s_tready;
    assign out_acc  = m_tvalid && m_tready;
    assign do_issue = (state_reg == ST_SCAN) && (issue_reg < count_reg);
    assign rd_pos   = POS_W'(rd_idx_reg);
    assign best_pos = POS_W'(best_idx_reg);
    assign rd_key   = make_key(sort_major_reg, rd_data_reg, rd_pos);
    assign take     = rd_vld_reg && (!have_prev_reg || rd_key > prev_key_reg)
                      && (!have_best_reg || rd_key < best_key_reg);
    assign is_final = (emit_reg + CNT_W'(1)) == count_reg;

    assign cfg_ready = 1'b1;
    assign m_tdata   = {(M_DATA_W - KEY_W - VALUE_W)'(0), best_pos, best_reg.value,
                        best_reg.col, best_reg.row};
    assign m_tlast   = is_final;
    assign m_tuser   = ovf_reg;

    always_ff @(posedge aclk) begin
        if (in_acc && count_reg < MaxCnt) begin
            mem[count_reg[IDX_W-1:0]] <= in_entry;
        end
        if (do_issue) begin
            rd_data_reg <= mem[issue_reg[IDX_W-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        s_tready   = 1'b0;
        m_tvalid   = 1'b0;
        unique case (state_reg)
            ST_LOAD: begin
                s_tready = 1'b1;
                if (s_tvalid && s_tlast) begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (rd_vld_reg && rd_last_reg) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                m_tvalid = 1'b1;
                if (m_tready) begin
                    state_next = is_final ? ST_LOAD : ST_SCAN;
                end
            end
            default: state_next = ST_LOAD;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_major_reg <= 1'b0;
            sort_major_reg <= 1'b0;
            count_reg     <= '0;
            ovf_reg       <= 1'b0;
            issue_reg     <= '0;
            emit_reg      <= '0;
            rd_vld_reg    <= 1'b0;
            rd_last_reg   <= 1'b0;
            have_prev_reg <= 1'b0;
            have_best_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                col_major_reg <= cfg_data;
            end
            rd_vld_reg  <= do_issue;
            rd_last_reg <= do_issue && (issue_reg + CNT_W'(1) == count_reg);
            if (do_issue) begin
                issue_reg  <= issue_reg + CNT_W'(1);
                rd_idx_reg <= issue_reg[IDX_W-1:0];
            end
            if (in_acc) begin
                if (count_reg < MaxCnt) begin
                    count_reg <= count_reg + CNT_W'(1);
                end else begin
                    ovf_reg <= 1'b1;
                end
                if (s_tlast) begin
                    sort_major_reg <= col_major_reg;
                    issue_reg      <= '0;
                    emit_reg       <= '0;
                    have_prev_reg  <= 1'b0;
                    have_best_reg  <= 1'b0;
                end
            end
            if (take) begin
                have_best_reg <= 1'b1;
                best_key_reg  <= rd_key;
                best_reg      <= rd_data_reg;
                best_idx_reg  <= rd_idx_reg;
            end
            // advance to the next smallest key once this beat is taken
            if (out_acc) begin
                have_prev_reg <= 1'b1;
                prev_key_reg  <= best_key_reg;
                have_best_reg <= 1'b0;
                issue_reg     <= '0;
                emit_reg      <= emit_reg + CNT_W'(1);
                if (is_final) begin
                    count_reg <= '0;
                    ovf_reg   <= 1'b0;
                end
            end
        end
    end

    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("input and output open together");
    a_emit_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (emit_reg < count_reg)) else $error("emit past stored count");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= MaxCnt) else $error("entry count beyond capacity");
    a_set_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_acc && m_tlast) |=> (count_reg == '0 && !ovf_reg))
        else $error("set not cleared after final beat");
    a_best_found: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> have_best_reg) else $error("result without a selected entry");

endmodule
